// ----- sv/cfa_pkg.sv -----
// Shared types and constants for the contiguous fit allocator.
// Used by cfa_ctrl, cfa_datapath and contiguous_fit_allocator.
package cfa_pkg;

  localparam int FUNC_W   = 2;
  localparam int FIT_W    = 2;
  localparam int SIZE_W   = 17;
  localparam int CFG_W    = 17;
  localparam int STATUS_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPACT = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_REPORT  = 2'd3;

  localparam logic [FIT_W-1:0] FIT_FIRST   = 2'd0;
  localparam logic [FIT_W-1:0] FIT_BEST    = 2'd1;
  localparam logic [FIT_W-1:0] FIT_WORST   = 2'd2;
  localparam logic [FIT_W-1:0] FIT_INVALID = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_ALLOC      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_RELEASED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_COMPACT_OK = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_RELOC      = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_LISTED     = 3'd6;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd7;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_START,
    CMD_SCAN_REQ,
    CMD_PREP_SHIFT,
    CMD_SHIFT,
    CMD_SPLIT,
    CMD_ALLOC,
    CMD_FAIL_NOFIT,
    CMD_FAIL_FULL,
    CMD_FAIL_NOTFOUND,
    CMD_SCAN_REL,
    CMD_FREE,
    CMD_MERGE_INIT,
    CMD_MERGE,
    CMD_MERGE_FLUSH,
    CMD_EMIT_C4,
    CMD_PACK_INIT,
    CMD_PACK,
    CMD_PACK_TAIL,
    CMD_REPORT
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic idx_end;
    logic found;
    logic split;
    logic full;
    logic bad_req;
    logic shift_done;
    logic few_holes;
  } dp_status_t;

endpackage

// ----- sv/cfa_datapath.sv -----
// Segment table, scan/shift/merge/pack datapath and result registers.
// Driven by cfa_ctrl commands; uses cfa_pkg.
module cfa_datapath #(
  parameter int MAX_SEGMENTS = 32,
  parameter int ADDR_BITS    = 16,
  parameter int OWNER_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfa_pkg::cmd_t                 cmd,
  output cfa_pkg::dp_status_t           status,
  input  logic                          cfg_wr,
  input  logic [cfa_pkg::CFG_W-1:0]     cfg_data,
  input  logic [OWNER_BITS-1:0]         in_owner_id,
  input  logic [cfa_pkg::SIZE_W-1:0]    in_request_size,
  input  logic [cfa_pkg::FIT_W-1:0]     in_fit_strategy,
  output logic                          out_strobe,
  output logic [cfa_pkg::STATUS_W-1:0]  out_status,
  output logic [OWNER_BITS-1:0]         out_owner_out,
  output logic                          out_in_use,
  output logic [ADDR_BITS-1:0]          out_first_address,
  output logic [ADDR_BITS-1:0]          out_last_address,
  output logic                          out_last_item
);

  localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int LW   = ADDR_BITS + 1;
  localparam int CMPW = (LW > cfa_pkg::SIZE_W) ? LW : cfa_pkg::SIZE_W;
  localparam logic [ADDR_BITS-1:0] RST_LAST =
    (ADDR_BITS >= 16) ? ADDR_BITS'(17'd65535) : {ADDR_BITS{1'b1}};

  logic [ADDR_BITS-1:0]  st_r [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0]  en_r [MAX_SEGMENTS];
  logic [OWNER_BITS-1:0] ow_r [MAX_SEGMENTS];
  logic                  us_r [MAX_SEGMENTS];

  logic [ADDR_BITS-1:0]  rd_st_r, rd_en_r;
  logic [OWNER_BITS-1:0] rd_ow_r;
  logic                  rd_us_r;

  logic [ADDR_BITS-1:0] msize_last_r, msize_last_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt, wr_r, wr_nxt;
  logic [CW-1:0] holes_r, holes_nxt, usedc_r, usedc_nxt, k_r, k_nxt;
  logic [OWNER_BITS-1:0] own_r, own_nxt;
  logic [cfa_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [cfa_pkg::FIT_W-1:0] strat_r, strat_nxt;
  logic found_r, found_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic [ADDR_BITS-1:0] pst_r, pst_nxt, pend_r, pend_nxt;
  logic [LW-1:0] blen_r, blen_nxt, addr_r, addr_nxt;
  logic [ADDR_BITS-1:0] mst_r, mst_nxt, men_r, men_nxt;
  logic [OWNER_BITS-1:0] mow_r, mow_nxt;
  logic mus_r, mus_nxt, mv_r, mv_nxt;

  logic o_stb_r, o_stb_nxt, o_use_r, o_use_nxt, o_last_r, o_last_nxt;
  logic [cfa_pkg::STATUS_W-1:0] o_stat_r, o_stat_nxt;
  logic [OWNER_BITS-1:0] o_own_r, o_own_nxt;
  logic [ADDR_BITS-1:0] o_first_r, o_first_nxt, o_lastad_r, o_lastad_nxt;

  logic wr_en;
  logic [IW-1:0] wa, ra;
  logic [ADDR_BITS-1:0] wst, wen, rst_v, ren_v;
  logic [OWNER_BITS-1:0] wow, row_v;
  logic wus, rus_v;
  logic [LW-1:0] rlen, pend_sum;
  logic [CMPW-1:0] rlen_x, size_x, split_sum;
  logic [32:0] cfg_x, cfg_lim;
  logic [ADDR_BITS-1:0] cfg_last;

  // read data of entry idx_r, fetched at the edge that loads idx_r
  assign ra     = idx_nxt[IW-1:0];
  assign rst_v  = rd_st_r;
  assign ren_v  = rd_en_r;
  assign row_v  = rd_ow_r;
  assign rus_v  = rd_us_r;
  assign rlen   = {1'b0, ren_v} - {1'b0, rst_v} + LW'(1);
  assign rlen_x = CMPW'(rlen);
  assign size_x = CMPW'(size_r);
  assign split_sum = CMPW'(pst_r) + size_x;
  assign pend_sum  = addr_r + rlen - LW'(1);

  assign cfg_x   = 33'(cfg_data);
  assign cfg_lim = 33'(1) << ADDR_BITS;
  always_comb begin
    if (cfg_x == '0) begin
      cfg_last = '0;
    end else if (cfg_x > cfg_lim) begin
      cfg_last = '1;
    end else begin
      cfg_last = ADDR_BITS'(cfg_x - 33'(1));
    end
  end

  always_comb begin
    msize_last_nxt = cfg_wr ? cfg_last : msize_last_r;
    cnt_nxt = cnt_r;  idx_nxt = idx_r;  wr_nxt = wr_r;
    holes_nxt = holes_r;  usedc_nxt = usedc_r;  k_nxt = k_r;
    own_nxt = own_r;  size_nxt = size_r;  strat_nxt = strat_r;
    found_nxt = found_r;  pick_nxt = pick_r;
    pst_nxt = pst_r;  pend_nxt = pend_r;  blen_nxt = blen_r;  addr_nxt = addr_r;
    mst_nxt = mst_r;  men_nxt = men_r;  mow_nxt = mow_r;  mus_nxt = mus_r;
    mv_nxt = mv_r;
    o_stb_nxt = 1'b0;  o_stat_nxt = o_stat_r;  o_own_nxt = o_own_r;
    o_use_nxt = o_use_r;  o_first_nxt = o_first_r;  o_lastad_nxt = o_lastad_r;
    o_last_nxt = o_last_r;
    wr_en = 1'b0;  wa = '0;  wst = '0;  wen = '0;  wow = '0;  wus = 1'b0;
    case (cmd)
      cfa_pkg::CMD_INIT: begin
        wr_en = 1'b1;  wen = msize_last_r;
        cnt_nxt = CW'(1);
      end
      cfa_pkg::CMD_START: begin
        own_nxt = in_owner_id;  size_nxt = in_request_size;
        strat_nxt = in_fit_strategy;
        idx_nxt = '0;  found_nxt = 1'b0;  pick_nxt = '0;
      end
      cfa_pkg::CMD_SCAN_REQ: begin
        if (!rus_v && rlen_x >= size_x &&
            (!found_r || (strat_r == cfa_pkg::FIT_BEST && rlen < blen_r) ||
             (strat_r == cfa_pkg::FIT_WORST && rlen > blen_r))) begin
          found_nxt = 1'b1;  pick_nxt = idx_r[IW-1:0];
          pst_nxt = rst_v;  pend_nxt = ren_v;  blen_nxt = rlen;
        end
        idx_nxt = idx_r + 1'b1;
      end
      cfa_pkg::CMD_PREP_SHIFT: begin
        wr_nxt = cnt_r;
        idx_nxt = cnt_r - 1'b1;
      end
      cfa_pkg::CMD_SHIFT: begin
        wr_en = 1'b1;  wa = wr_r[IW-1:0];
        wst = rst_v;  wen = ren_v;  wow = row_v;  wus = rus_v;
        wr_nxt = wr_r - 1'b1;
        idx_nxt = idx_r - 1'b1;
      end
      cfa_pkg::CMD_SPLIT: begin
        wr_en = 1'b1;  wa = pick_r + 1'b1;
        wst = split_sum[ADDR_BITS-1:0];  wen = pend_r;
        cnt_nxt = cnt_r + 1'b1;
        pend_nxt = ADDR_BITS'(split_sum - CMPW'(1));
      end
      cfa_pkg::CMD_ALLOC: begin
        wr_en = 1'b1;  wa = pick_r;
        wst = pst_r;  wen = pend_r;  wow = own_r;  wus = 1'b1;
        o_stb_nxt = 1'b1;  o_stat_nxt = cfa_pkg::STAT_ALLOC;  o_own_nxt = own_r;
        o_use_nxt = 1'b1;  o_first_nxt = pst_r;  o_lastad_nxt = pend_r;
        o_last_nxt = 1'b1;
      end
      cfa_pkg::CMD_FAIL_NOFIT, cfa_pkg::CMD_FAIL_FULL,
      cfa_pkg::CMD_FAIL_NOTFOUND: begin
        o_stb_nxt = 1'b1;  o_own_nxt = own_r;  o_use_nxt = 1'b0;
        o_first_nxt = '0;  o_lastad_nxt = '0;  o_last_nxt = 1'b1;
        if (cmd == cfa_pkg::CMD_FAIL_NOFIT) begin
          o_stat_nxt = cfa_pkg::STAT_NOFIT;
        end else if (cmd == cfa_pkg::CMD_FAIL_FULL) begin
          o_stat_nxt = cfa_pkg::STAT_FULL;
        end else begin
          o_stat_nxt = cfa_pkg::STAT_NOTFOUND;
        end
      end
      cfa_pkg::CMD_SCAN_REL: begin
        if (!found_r && rus_v && row_v == own_r) begin
          found_nxt = 1'b1;  pick_nxt = idx_r[IW-1:0];
          pst_nxt = rst_v;  pend_nxt = ren_v;
        end
        idx_nxt = idx_r + 1'b1;
      end
      cfa_pkg::CMD_FREE: begin
        wr_en = 1'b1;  wa = pick_r;  wst = pst_r;  wen = pend_r;
        o_stb_nxt = 1'b1;  o_stat_nxt = cfa_pkg::STAT_RELEASED;  o_own_nxt = own_r;
        o_use_nxt = 1'b0;  o_first_nxt = pst_r;  o_lastad_nxt = pend_r;
        o_last_nxt = 1'b1;
      end
      cfa_pkg::CMD_MERGE_INIT: begin
        idx_nxt = '0;  wr_nxt = '0;  holes_nxt = '0;  usedc_nxt = '0;
        mv_nxt = 1'b0;
      end
      cfa_pkg::CMD_MERGE: begin
        if (!mv_r) begin
          mst_nxt = rst_v;  men_nxt = ren_v;  mow_nxt = row_v;  mus_nxt = rus_v;
          mv_nxt = 1'b1;
        end else if (!mus_r && !rus_v) begin
          men_nxt = ren_v;
        end else begin
          wr_en = 1'b1;  wa = wr_r[IW-1:0];
          wst = mst_r;  wen = men_r;  wow = mow_r;  wus = mus_r;
          wr_nxt = wr_r + 1'b1;
          if (mus_r) begin
            usedc_nxt = usedc_r + 1'b1;
          end else begin
            holes_nxt = holes_r + 1'b1;
          end
          mst_nxt = rst_v;  men_nxt = ren_v;  mow_nxt = row_v;  mus_nxt = rus_v;
        end
        idx_nxt = idx_r + 1'b1;
      end
      cfa_pkg::CMD_MERGE_FLUSH: begin
        wr_en = 1'b1;  wa = wr_r[IW-1:0];
        wst = mst_r;  wen = men_r;  wow = mow_r;  wus = mus_r;
        if (mus_r) begin
          usedc_nxt = usedc_r + 1'b1;
        end else begin
          holes_nxt = holes_r + 1'b1;
        end
        cnt_nxt = wr_r + 1'b1;
      end
      cfa_pkg::CMD_EMIT_C4: begin
        o_stb_nxt = 1'b1;  o_stat_nxt = cfa_pkg::STAT_COMPACT_OK;  o_own_nxt = '0;
        o_use_nxt = 1'b0;  o_first_nxt = '0;  o_lastad_nxt = '0;  o_last_nxt = 1'b1;
      end
      cfa_pkg::CMD_PACK_INIT: begin
        idx_nxt = '0;  wr_nxt = '0;  addr_nxt = '0;  k_nxt = '0;
      end
      cfa_pkg::CMD_PACK: begin
        if (rus_v) begin
          wr_en = 1'b1;  wa = wr_r[IW-1:0];
          wst = addr_r[ADDR_BITS-1:0];  wen = pend_sum[ADDR_BITS-1:0];
          wow = row_v;  wus = 1'b1;
          o_stb_nxt = 1'b1;  o_stat_nxt = cfa_pkg::STAT_RELOC;  o_own_nxt = row_v;
          o_use_nxt = 1'b1;  o_first_nxt = addr_r[ADDR_BITS-1:0];
          o_lastad_nxt = pend_sum[ADDR_BITS-1:0];
          o_last_nxt = (k_r == usedc_r - 1'b1);
          wr_nxt = wr_r + 1'b1;  k_nxt = k_r + 1'b1;  addr_nxt = addr_r + rlen;
        end
        idx_nxt = idx_r + 1'b1;
      end
      cfa_pkg::CMD_PACK_TAIL: begin
        wr_en = 1'b1;  wa = wr_r[IW-1:0];
        wst = addr_r[ADDR_BITS-1:0];  wen = msize_last_r;
        cnt_nxt = wr_r + 1'b1;
      end
      cfa_pkg::CMD_REPORT: begin
        o_stb_nxt = 1'b1;  o_stat_nxt = cfa_pkg::STAT_LISTED;
        o_own_nxt = rus_v ? row_v : '0;  o_use_nxt = rus_v;
        o_first_nxt = rst_v;  o_lastad_nxt = ren_v;
        o_last_nxt = (idx_r == cnt_r - 1'b1);
        idx_nxt = idx_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      st_r[wa] <= wst;
      en_r[wa] <= wen;
      ow_r[wa] <= wow;
      us_r[wa] <= wus;
    end
    rd_st_r <= st_r[ra];
    rd_en_r <= en_r[ra];
    rd_ow_r <= ow_r[ra];
    rd_us_r <= us_r[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msize_last_r <= RST_LAST;
      cnt_r        <= CW'(1);
      o_stb_r      <= 1'b0;
    end else begin
      msize_last_r <= msize_last_nxt;
      cnt_r        <= cnt_nxt;
      o_stb_r      <= o_stb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;  wr_r <= wr_nxt;
    holes_r <= holes_nxt;  usedc_r <= usedc_nxt;  k_r <= k_nxt;
    own_r <= own_nxt;  size_r <= size_nxt;  strat_r <= strat_nxt;
    found_r <= found_nxt;  pick_r <= pick_nxt;
    pst_r <= pst_nxt;  pend_r <= pend_nxt;  blen_r <= blen_nxt;  addr_r <= addr_nxt;
    mst_r <= mst_nxt;  men_r <= men_nxt;  mow_r <= mow_nxt;  mus_r <= mus_nxt;
    mv_r <= mv_nxt;
    o_stat_r <= o_stat_nxt;  o_own_r <= o_own_nxt;  o_use_r <= o_use_nxt;
    o_first_r <= o_first_nxt;  o_lastad_r <= o_lastad_nxt;  o_last_r <= o_last_nxt;
  end

  assign status.idx_last   = (idx_r == cnt_r - 1'b1);
  assign status.idx_end    = (idx_r == cnt_r);
  assign status.found      = found_r;
  assign status.split      = (CMPW'(blen_r) > size_x);
  assign status.full       = (cnt_r >= CW'(MAX_SEGMENTS));
  assign status.bad_req    = (strat_r == cfa_pkg::FIT_INVALID) || (size_r == '0);
  assign status.shift_done = (wr_r == CW'(pick_r) + 1'b1);
  assign status.few_holes  = (holes_r < CW'(2));

  assign out_strobe        = o_stb_r;
  assign out_status        = o_stat_r;
  assign out_owner_out     = o_own_r;
  assign out_in_use        = o_use_r;
  assign out_first_address = o_first_r;
  assign out_last_address  = o_lastad_r;
  assign out_last_item     = o_last_r;

endmodule

// ----- sv/cfa_ctrl.sv -----
// Operation sequencer for the contiguous fit allocator.
// Issues cfa_pkg::cmd_t commands to cfa_datapath from its status.
module cfa_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       cfg_wr,
  input  logic [cfa_pkg::FUNC_W-1:0] in_func,
  input  cfa_pkg::dp_status_t        status,
  output cfa_pkg::cmd_t              cmd,
  output logic                       busy
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_REQ_SCAN, S_REQ_DEC, S_SHIFT, S_ALLOC,
    S_REL_SCAN, S_REL_DEC, S_MINIT, S_MERGE, S_CDEC, S_PACK, S_PTAIL, S_REPORT
  } state_t;

  state_t state_r, state_nxt;
  logic   cmp_r, cmp_nxt, busy_r;

  always_comb begin
    state_nxt = state_r;
    cmp_nxt   = cmp_r;
    cmd       = cfa_pkg::CMD_NONE;
    case (state_r)
      S_INIT: begin
        cmd = cfa_pkg::CMD_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_wr) begin
          state_nxt = S_INIT;
        end else if (start) begin
          cmd = cfa_pkg::CMD_START;
          case (in_func)
            cfa_pkg::FUNC_REQUEST: state_nxt = S_REQ_SCAN;
            cfa_pkg::FUNC_RELEASE: begin
              state_nxt = S_REL_SCAN;
              cmp_nxt = 1'b0;
            end
            cfa_pkg::FUNC_COMPACT: begin
              state_nxt = S_MINIT;
              cmp_nxt = 1'b1;
            end
            default: state_nxt = S_REPORT;
          endcase
        end
      end
      S_REQ_SCAN: begin
        cmd = cfa_pkg::CMD_SCAN_REQ;
        if (status.idx_last) state_nxt = S_REQ_DEC;
      end
      S_REQ_DEC: begin
        if (status.bad_req || !status.found) begin
          cmd = cfa_pkg::CMD_FAIL_NOFIT;
          state_nxt = S_IDLE;
        end else if (status.split && status.full) begin
          cmd = cfa_pkg::CMD_FAIL_FULL;
          state_nxt = S_IDLE;
        end else if (status.split) begin
          cmd = cfa_pkg::CMD_PREP_SHIFT;
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_ALLOC;
        end
      end
      S_SHIFT: begin
        if (status.shift_done) begin
          cmd = cfa_pkg::CMD_SPLIT;
          state_nxt = S_ALLOC;
        end else begin
          cmd = cfa_pkg::CMD_SHIFT;
        end
      end
      S_ALLOC: begin
        cmd = cfa_pkg::CMD_ALLOC;
        state_nxt = S_IDLE;
      end
      S_REL_SCAN: begin
        cmd = cfa_pkg::CMD_SCAN_REL;
        if (status.idx_last) state_nxt = S_REL_DEC;
      end
      S_REL_DEC: begin
        if (status.found) begin
          cmd = cfa_pkg::CMD_FREE;
          state_nxt = S_MINIT;
        end else begin
          cmd = cfa_pkg::CMD_FAIL_NOTFOUND;
          state_nxt = S_IDLE;
        end
      end
      S_MINIT: begin
        cmd = cfa_pkg::CMD_MERGE_INIT;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        if (status.idx_end) begin
          cmd = cfa_pkg::CMD_MERGE_FLUSH;
          state_nxt = cmp_r ? S_CDEC : S_IDLE;
        end else begin
          cmd = cfa_pkg::CMD_MERGE;
        end
      end
      S_CDEC: begin
        if (status.few_holes) begin
          cmd = cfa_pkg::CMD_EMIT_C4;
          state_nxt = S_IDLE;
        end else begin
          cmd = cfa_pkg::CMD_PACK_INIT;
          state_nxt = S_PACK;
        end
      end
      S_PACK: begin
        cmd = cfa_pkg::CMD_PACK;
        if (status.idx_last) state_nxt = S_PTAIL;
      end
      S_PTAIL: begin
        cmd = cfa_pkg::CMD_PACK_TAIL;
        state_nxt = S_IDLE;
      end
      S_REPORT: begin
        cmd = cfa_pkg::CMD_REPORT;
        if (status.idx_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cmp_r   <= 1'b0;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cmp_r   <= cmp_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ----- sv/contiguous_fit_allocator.sv -----
// Contiguous fit allocator top level: cfa_ctrl sequencer plus cfa_datapath.
// Depends on cfa_pkg.
//
// Usage: pulse start with in_func and its operands while busy is low; the word
// is taken on that edge and busy rises on the next cycle until the operation
// ends. Results appear on the out_ ports, each qualified by
// out_strobe for exactly one cycle; out_last_item marks the final one. The
// receiver cannot stall, so results are simply presented and consumed.
// A request scans the table, then shifts the entries above the picked hole
// when that hole splits; a release scans for the owner's segment, then runs a
// merge pass over the free holes; compact merges, then packs the used segments
// when two or more holes remain; a report lists one segment per cycle. The
// segment table has one write port and one registered read port.
// cfg_data sets memory_size via cfg_valid/cfg_ready, accepted only while idle
// with start low; the table is then reset to one hole. After reset the block is
// busy while it loads a single hole of the reset memory size.
module contiguous_fit_allocator #(
  parameter int MAX_SEGMENTS = 32,
  parameter int ADDR_BITS    = 16,
  parameter int OWNER_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cfa_pkg::FUNC_W-1:0]    in_func,
  input  logic [OWNER_BITS-1:0]         in_owner_id,
  input  logic [cfa_pkg::SIZE_W-1:0]    in_request_size,
  input  logic [cfa_pkg::FIT_W-1:0]     in_fit_strategy,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cfa_pkg::CFG_W-1:0]     cfg_data,
  output logic                          out_strobe,
  output logic [cfa_pkg::STATUS_W-1:0]  out_status,
  output logic [OWNER_BITS-1:0]         out_owner_out,
  output logic                          out_in_use,
  output logic [ADDR_BITS-1:0]          out_first_address,
  output logic [ADDR_BITS-1:0]          out_last_address,
  output logic                          out_last_item
);

  cfa_pkg::cmd_t       cmd;
  cfa_pkg::dp_status_t status;
  logic                cfg_wr;
  logic                busy_i;

  assign cfg_ready = !busy_i && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = busy_i;

  cfa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cfg_wr  (cfg_wr),
    .in_func (in_func),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy_i)
  );

  cfa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS),
    .OWNER_BITS   (OWNER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_wr            (cfg_wr),
    .cfg_data          (cfg_data),
    .in_owner_id       (in_owner_id),
    .in_request_size   (in_request_size),
    .in_fit_strategy   (in_fit_strategy),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_owner_out     (out_owner_out),
    .out_in_use        (out_in_use),
    .out_first_address (out_first_address),
    .out_last_address  (out_last_address),
    .out_last_item     (out_last_item)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for contiguous_fit_allocator: directed table, then random traffic.
// Expected results come from a segment table model kept in this file.
// Depends on cfa_pkg and the contiguous_fit_allocator RTL.
`timescale 1ns / 100ps

module tb;

  localparam int NSEG = 32;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  owner;
    logic        in_use;
    logic [15:0] first;
    logic [15:0] last;
    logic        last_item;
  } seg_word_t;

  typedef struct {
    int is_cfg;
    int func;
    int owner;
    int size;
    int fit;
    int typed;
    int e_st;
    int e_own;
    int e_use;
    int e_first;
    int e_last;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [7:0] in_owner_id = '0;
  logic [16:0] in_request_size = '0;
  logic [1:0] in_fit_strategy = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [16:0] cfg_data = '0;
  logic out_strobe;
  logic [2:0] out_status;
  logic [7:0] out_owner_out;
  logic out_in_use;
  logic [15:0] out_first_address;
  logic [15:0] out_last_address;
  logic out_last_item;

  seg_word_t expected_words[$];
  stim_row_t dir_rows[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1;

  int mem_units;
  int seg_first[NSEG];
  int seg_last[NSEG];
  int seg_own[NSEG];
  bit seg_busy[NSEG];
  int seg_cnt;

  contiguous_fit_allocator dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function automatic void push_word(int st, int own, int use_bit, int f, int l, int lst);
    seg_word_t w;
    w.status = st[2:0];
    w.owner = own[7:0];
    w.in_use = use_bit[0];
    w.first = f[15:0];
    w.last = l[15:0];
    w.last_item = lst[0];
    expected_words = {expected_words, w};
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void table_clear(int v);
    v = v & 32'h1FFFF;
    if (v == 0) v = 1;
    if (v > 65536) v = 65536;
    mem_units = v;
    for (int i = 0; i < NSEG; i++) begin
      seg_first[i] = 0;
      seg_last[i] = 0;
      seg_own[i] = 0;
      seg_busy[i] = 0;
    end
    seg_last[0] = mem_units - 1;
    seg_cnt = 1;
  endfunction

  function automatic void merge_free();
    int i;
    i = 0;
    while (i + 1 < seg_cnt) begin
      if (!seg_busy[i] && !seg_busy[i+1]) begin
        seg_last[i] = seg_last[i+1];
        for (int j = i + 1; j + 1 < seg_cnt; j++) begin
          seg_first[j] = seg_first[j+1];
          seg_last[j] = seg_last[j+1];
          seg_own[j] = seg_own[j+1];
          seg_busy[j] = seg_busy[j+1];
        end
        seg_cnt--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic void place_block(int own, int size, int fit);
    int pick, len, plen;
    bit found;
    pick = 0;
    found = 0;
    if (fit == cfa_pkg::FIT_INVALID || size == 0) begin
      push_word(cfa_pkg::STAT_NOFIT, own, 0, 0, 0, 1);
      return;
    end
    for (int i = 0; i < seg_cnt; i++) begin
      len = seg_last[i] - seg_first[i] + 1;
      plen = seg_last[pick] - seg_first[pick] + 1;
      if (seg_busy[i] || len < size) continue;
      if (fit == cfa_pkg::FIT_FIRST) begin
        pick = i;
        found = 1;
        break;
      end
      if (!found || (fit == cfa_pkg::FIT_BEST && len < plen) ||
          (fit == cfa_pkg::FIT_WORST && len > plen)) begin
        pick = i;
        found = 1;
      end
    end
    if (!found) begin
      push_word(cfa_pkg::STAT_NOFIT, own, 0, 0, 0, 1);
      return;
    end
    if (seg_last[pick] - seg_first[pick] + 1 > size) begin
      if (seg_cnt >= NSEG) begin
        push_word(cfa_pkg::STAT_FULL, own, 0, 0, 0, 1);
        return;
      end
      for (int j = seg_cnt; j > pick + 1; j--) begin
        seg_first[j] = seg_first[j-1];
        seg_last[j] = seg_last[j-1];
        seg_own[j] = seg_own[j-1];
        seg_busy[j] = seg_busy[j-1];
      end
      seg_first[pick+1] = seg_first[pick] + size;
      seg_last[pick+1] = seg_last[pick];
      seg_own[pick+1] = 0;
      seg_busy[pick+1] = 0;
      seg_last[pick] = seg_first[pick] + size - 1;
      seg_cnt++;
    end
    seg_busy[pick] = 1;
    seg_own[pick] = own;
    push_word(cfa_pkg::STAT_ALLOC, own, 1, seg_first[pick], seg_last[pick], 1);
  endfunction

  function automatic void free_block(int own);
    int f, l;
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_busy[i] && seg_own[i] == own) begin
        f = seg_first[i];
        l = seg_last[i];
        seg_busy[i] = 0;
        seg_own[i] = 0;
        merge_free();
        push_word(cfa_pkg::STAT_RELEASED, own, 0, f, l, 1);
        return;
      end
    end
    push_word(cfa_pkg::STAT_NOTFOUND, own, 0, 0, 0, 1);
  endfunction

  function automatic void pack_blocks();
    int holes, n, addr, len;
    holes = 0;
    n = 0;
    addr = 0;
    merge_free();
    for (int i = 0; i < seg_cnt; i++) if (!seg_busy[i]) holes++;
    if (holes < 2) begin
      push_word(cfa_pkg::STAT_COMPACT_OK, 0, 0, 0, 0, 1);
      return;
    end
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_busy[i]) begin
        len = seg_last[i] - seg_first[i] + 1;
        seg_own[n] = seg_own[i];
        seg_busy[n] = 1;
        seg_first[n] = addr;
        seg_last[n] = addr + len - 1;
        push_word(cfa_pkg::STAT_RELOC, seg_own[n], 1, seg_first[n], seg_last[n], 0);
        n++;
        addr += len;
      end
    end
    seg_first[n] = addr;
    seg_last[n] = mem_units - 1;
    seg_own[n] = 0;
    seg_busy[n] = 0;
    seg_cnt = n + 1;
    expected_words[expected_words.size()-1].last_item = 1;
  endfunction

  function automatic void predict_op(int f, int own, int size, int fit);
    case (f)
      cfa_pkg::FUNC_REQUEST: place_block(own, size, fit);
      cfa_pkg::FUNC_RELEASE: free_block(own);
      cfa_pkg::FUNC_COMPACT: pack_blocks();
      default: begin
        for (int i = 0; i < seg_cnt; i++)
          push_word(cfa_pkg::STAT_LISTED, seg_busy[i] ? seg_own[i] : 0, seg_busy[i],
                    seg_first[i], seg_last[i], i + 1 == seg_cnt);
      end
    endcase
  endfunction

  task automatic send_op(int f, int own, int size, int fit);
    if (idle_on && ($urandom % 3 == 0)) repeat ($urandom_range(1, 19)) @(posedge clk);
    @(posedge clk);
    start <= 1;
    in_func <= f[1:0];
    in_owner_id <= own[7:0];
    in_request_size <= size[16:0];
    in_fit_strategy <= fit[1:0];
    do @(posedge clk); while (busy);
    predict_op(f, own, size, fit);
    start <= 0;
  endtask

  task automatic write_size(int v);
    while (expected_words.size() != 0 || busy) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v[16:0];
    do @(posedge clk); while (!cfg_ready);
    table_clear(v);
    cfg_valid <= 0;
  endtask

  task automatic random_op(int max_req, int req_pct);
    int r, f, own, size, fit, live[$], h[$];
    r = $urandom_range(0, 99);
    own = $urandom_range(0, 255);
    size = 1;
    fit = $urandom_range(0, 2);
    if (r < req_pct) begin
      f = cfa_pkg::FUNC_REQUEST;
      r = $urandom_range(0, 19);
      for (int i = 0; i < seg_cnt; i++) if (!seg_busy[i]) h = {h, i};
      if (r == 0) fit = cfa_pkg::FIT_INVALID;
      if (r == 1) size = $urandom_range(0, 131071);
      else if (r < 5 && h.size() != 0) begin
        r = h[$urandom_range(0, h.size() - 1)];
        size = seg_last[r] - seg_first[r] + 1;
      end else size = $urandom_range(1, max_req);
    end else if (r < req_pct + (100 - req_pct) / 2) begin
      f = cfa_pkg::FUNC_RELEASE;
      for (int i = 0; i < seg_cnt; i++) if (seg_busy[i]) live = {live, seg_own[i]};
      if (live.size() != 0 && $urandom % 5 != 0) own = live[$urandom_range(0, live.size() - 1)];
    end else if ($urandom % 2) f = cfa_pkg::FUNC_COMPACT;
    else f = cfa_pkg::FUNC_REPORT;
    size = size & 32'h1FFFF;
    send_op(f, own, size, $urandom % 2 ? fit : (fit | ($urandom_range(0, 3) & 0)));
  endtask

  always @(posedge clk) begin
    seg_word_t w;
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: status %0d owner %0d use %0d %0d..%0d last %0d",
                 $time, out_status, out_owner_out, out_in_use, out_first_address,
                 out_last_address, out_last_item);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (w.status !== out_status || w.owner !== out_owner_out || w.in_use !== out_in_use ||
            w.first !== out_first_address || w.last !== out_last_address ||
            w.last_item !== out_last_item) begin
          $display("%0t mismatch: exp status %0d owner %0d use %0d %0d..%0d last %0d", $time,
                   w.status, w.owner, w.in_use, w.first, w.last, w.last_item);
          $display("%0t           act status %0d owner %0d use %0d %0d..%0d last %0d", $time,
                   out_status, out_owner_out, out_in_use, out_first_address,
                   out_last_address, out_last_item);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[contiguous_fit_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int msz[5];
    int mreq[5];
    int rpct[5];
    int wait_cnt;
    table_clear(65536);
    // {cfg, func, owner, size, fit, typed, status, owner, use, first, last}
    add_row('{0, cfa_pkg::FUNC_REPORT, 0, 1, 0, 1, cfa_pkg::STAT_LISTED, 0, 0, 0, 65535});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 255, 131071, 0, 1, cfa_pkg::STAT_NOFIT,
              255, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 5, 0, 1, 1, cfa_pkg::STAT_NOFIT, 5, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 6, 4, cfa_pkg::FIT_INVALID, 1, cfa_pkg::STAT_NOFIT,
              6, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_COMPACT, 0, 1, 0, 1, cfa_pkg::STAT_COMPACT_OK, 0, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_RELEASE, 7, 1, 0, 1, cfa_pkg::STAT_NOTFOUND, 7, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 1, 16, cfa_pkg::FIT_FIRST, 1, cfa_pkg::STAT_ALLOC,
              1, 1, 0, 15});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 2, 100, cfa_pkg::FIT_BEST, 0, 0, 0, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 3, 50, cfa_pkg::FIT_WORST, 0, 0, 0, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 9, 20, cfa_pkg::FIT_FIRST, 0, 0, 0, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_RELEASE, 1, 1, 0, 1, cfa_pkg::STAT_RELEASED, 1, 0, 0, 15});
    add_row('{0, cfa_pkg::FUNC_RELEASE, 3, 1, 0, 0, 0, 0, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 4, 8, cfa_pkg::FIT_BEST, 0, 0, 0, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 8, 8, cfa_pkg::FIT_WORST, 0, 0, 0, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_COMPACT, 0, 1, 0, 0, 0, 0, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REPORT, 0, 1, 0, 0, 0, 0, 0, 0, 0});
    add_row('{1, 0, 0, 131071, 0, 0, 0, 0, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 170, 65536, cfa_pkg::FIT_FIRST, 1,
              cfa_pkg::STAT_ALLOC, 170, 1, 0, 65535});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 85, 1, cfa_pkg::FIT_FIRST, 1, cfa_pkg::STAT_NOFIT,
              85, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_RELEASE, 170, 1, 0, 1, cfa_pkg::STAT_RELEASED,
              170, 0, 0, 65535});
    add_row('{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REQUEST, 0, 1, cfa_pkg::FIT_BEST, 1, cfa_pkg::STAT_ALLOC,
              0, 1, 0, 0});
    add_row('{0, cfa_pkg::FUNC_REPORT, 0, 1, 0, 1, cfa_pkg::STAT_LISTED, 0, 1, 0, 0});
    add_row('{1, 0, 0, 65536, 0, 0, 0, 0, 0, 0, 0});
    repeat (5) @(posedge clk);
    rst_n <= 1;
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.is_cfg) write_size(row.size);
      else begin
        send_op(row.func, row.owner, row.size, row.fit);
        if (row.typed) begin
          expected_words.pop_back();
          push_word(row.e_st, row.e_own, row.e_use, row.e_first, row.e_last, 1);
        end
      end
    end
    msz = '{65536, 256, $urandom_range(1, 65536), 1000, 65536};
    mreq = '{8000, 4, 0, 60, 3000};
    rpct = '{50, 75, 50, 55, 50};
    for (int p = 0; p < 5; p++) begin
      if (p != 0) write_size(msz[p]);
      if (p == 4) idle_on = 0;
      for (int n = 0; n < 48; n++)
        random_op(mreq[p] == 0 ? (mem_units + 3) / 4 : mreq[p], rpct[p]);
    end
    wait_cnt = 0;
    while (expected_words.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0)
      $display("[contiguous_fit_allocator] OK");
    else
      $display("[contiguous_fit_allocator] ERROR");
    $finish;
  end

endmodule
